// ===== src/ip_range_match_table_top_macros.svh =====
// Assertion macros of the range match table top level.
`ifndef IP_RANGE_MATCH_TABLE_TOP_MACROS_SVH
`define IP_RANGE_MATCH_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IRMT_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("irmt check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define IRMT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("irmt check failed");

`endif

// ===== src/irmt_pkg.sv =====
// Types, codes and helpers of the address range match table.
package irmt_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam logic [1:0] DEPTH_RESET = 2'd2;
  localparam logic [1:0] DEPTH_DEEP = 2'd3;
  localparam logic [1:0] LEVEL_LAST = 2'd3;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_MATCH    = 2'd2,
    ST_NOMATCH  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    MODE_INSERT = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [0:0]  mode;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic [15:0] entry_tag;
    logic [31:0] lookup_addr;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] match_tag;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [15:0] tag;
    logic [1:0]  level;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic insert;
    logic scan_step;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_lookup;
    logic empty;
    logic scan_last;
  } stat_t;

  // Index of the first differing byte from the top, capped at the depth.
  function automatic logic [1:0] level_of(input logic [31:0] lo, input logic [31:0] hi,
                                          input logic deep);
    logic [1:0] lvl;
    if (lo[31:24] != hi[31:24]) begin
      lvl = 2'd0;
    end else if (lo[23:16] != hi[23:16]) begin
      lvl = 2'd1;
    end else if (!deep || (lo[15:8] != hi[15:8])) begin
      lvl = 2'd2;
    end else begin
      lvl = 2'd3;
    end
    return lvl;
  endfunction

endpackage

// ===== src/irmt_ctrl.sv =====
// Sequencer for insert and lookup items of the range match table.
module irmt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  irmt_pkg::stat_t stat,
  output irmt_pkg::cmd_t  cmd
);

  irmt_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irmt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      irmt_pkg::S_IDLE: begin
        if (start) state_next = irmt_pkg::S_EXEC;
      end
      irmt_pkg::S_EXEC: begin
        if (!stat.is_lookup) state_next = irmt_pkg::S_IDLE;
        else if (stat.empty) state_next = irmt_pkg::S_DRAIN;
        else state_next = irmt_pkg::S_SCAN;
      end
      irmt_pkg::S_SCAN: begin
        if (stat.scan_last) state_next = irmt_pkg::S_DRAIN;
      end
      irmt_pkg::S_DRAIN: begin
        state_next = irmt_pkg::S_FINISH;
      end
      irmt_pkg::S_FINISH: begin
        state_next = irmt_pkg::S_IDLE;
      end
      default: state_next = irmt_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy          = (state != irmt_pkg::S_IDLE);
    cmd.load      = 1'b0;
    cmd.insert    = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.finish    = 1'b0;
    unique case (state)
      irmt_pkg::S_IDLE:   cmd.load = start;
      irmt_pkg::S_EXEC:   cmd.insert = !stat.is_lookup;
      irmt_pkg::S_SCAN:   cmd.scan_step = 1'b1;
      irmt_pkg::S_DRAIN:  ;
      irmt_pkg::S_FINISH: cmd.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== src/irmt_datapath.sv =====
// Entry memory, scan counters, range compare and result register.
module irmt_datapath #(
  parameter int MAX_ENTRIES = irmt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  irmt_pkg::in_item_t  item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_data,
  input  irmt_pkg::cmd_t      cmd,
  output irmt_pkg::stat_t     stat,
  output logic                strobe,
  output irmt_pkg::out_item_t result
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [1:0]             depth;
  logic [CNT_W-1:0]       count;
  irmt_pkg::in_item_t     cur;
  irmt_pkg::entry_t       mem [MAX_ENTRIES];
  irmt_pkg::entry_t       rd_data;
  logic                   rd_v;
  logic [1:0]             rd_lvl;
  logic [IDX_W-1:0]       cursor;
  logic [1:0]             lvl;
  logic                   pend_valid;
  logic [15:0]            pend_tag;
  logic                   full;
  logic                   level_end;
  logic                   hit;
  logic                   strobe_next;
  irmt_pkg::out_item_t    result_next;
  irmt_pkg::entry_t       wr_entry;

  assign full      = (count >= CNT_MAX);
  assign level_end = (CNT_W'(cursor) == (count - CNT_ONE));

  assign stat.is_lookup = (cur.mode == irmt_pkg::MODE_LOOKUP);
  assign stat.empty     = (count == '0);
  assign stat.scan_last = level_end && (lvl == irmt_pkg::LEVEL_LAST);

  // Entry built from the held insert item
  always_comb begin
    wr_entry.start_addr = cur.range_low;
    wr_entry.end_addr   = cur.range_high;
    wr_entry.tag        = cur.entry_tag;
    wr_entry.level      = irmt_pkg::level_of(cur.range_low, cur.range_high,
                                             depth == irmt_pkg::DEPTH_DEEP);
  end

  // Compare of the entry read last cycle against the lookup address
  assign hit = rd_v && (rd_data.level == rd_lvl) &&
               (cur.lookup_addr >= rd_data.start_addr) &&
               (cur.lookup_addr <= rd_data.end_addr);

  // Result selection: a match is held back one step so the final one gets last
  always_comb begin
    strobe_next           = 1'b0;
    result_next.status    = irmt_pkg::ST_NOMATCH;
    result_next.match_tag = 16'd0;
    result_next.last      = 1'b1;
    if (cmd.insert) begin
      strobe_next        = 1'b1;
      result_next.status = full ? irmt_pkg::ST_FULL : irmt_pkg::ST_INSERTED;
    end else if (cmd.finish) begin
      strobe_next = 1'b1;
      if (pend_valid) begin
        result_next.status    = irmt_pkg::ST_MATCH;
        result_next.match_tag = pend_tag;
      end
    end else if (hit && pend_valid) begin
      strobe_next           = 1'b1;
      result_next.status    = irmt_pkg::ST_MATCH;
      result_next.match_tag = pend_tag;
      result_next.last      = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= irmt_pkg::DEPTH_RESET;
      count      <= '0;
      rd_v       <= 1'b0;
      cursor     <= '0;
      lvl        <= 2'd0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      if (cfg_we) depth <= cfg_data;
      strobe <= strobe_next;
      rd_v   <= cmd.scan_step && !stat.empty;
      if (cmd.insert && !full) count <= count + CNT_ONE;
      if (cmd.load) begin
        cursor     <= '0;
        lvl        <= 2'd0;
        pend_valid <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          if (level_end) begin
            cursor <= '0;
            lvl    <= lvl + 2'd1;
          end else begin
            cursor <= cursor + IDX_W'(1);
          end
        end
        if (hit) pend_valid <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) cur <= item;
    if (hit) pend_tag <= rd_data.tag;
    if (strobe_next) result <= result_next;
    rd_lvl <= lvl;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.insert && !full) mem[count[IDX_W-1:0]] <= wr_entry;
    if (cmd.scan_step) rd_data <= mem[cursor];
  end

endmodule

// ===== src/ip_range_match_table_top.sv =====
// Top level of the address range match table.
//
//  channel   direction  handshake                      payload
//  item      in         start & !busy                  irmt_pkg::in_item_t
//  result    out        strobe, one cycle, no stall    irmt_pkg::out_item_t
//  cfg       in         cfg_valid & cfg_ready          cfg_data (lookup depth)
//
// Insert: the start transfer loads the item and the exec state forms the registered result strobe.
// Lookup: the scan reads the entry memory once per stored entry for each of the four levels;
// an empty table skips the scan.
// Matches stream out while scanning; the final result strobes after the drain and finish states.
// Synchronous reset empties the table and sets the depth to 2; no clearing pass.
// Results cannot be held off; cfg_ready is always high.
module ip_range_match_table_top #(
  parameter int MAX_ENTRIES = irmt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  irmt_pkg::in_item_t  item,
  output logic                strobe,
  output irmt_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);

`include "ip_range_match_table_top_macros.svh"

  irmt_pkg::cmd_t  cmd;
  irmt_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  irmt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  irmt_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .strobe   (strobe),
    .result   (result)
  );

  // An accepted item makes the block busy in the following cycle
  `IRMT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  // The finish step always delivers a final result
  `IRMT_ASSERT_NEXT(a_finish_last, cmd.finish, strobe && result.last)
  // Only matches can be followed by more results of the same item
  `IRMT_ASSERT_NOW(a_nonlast_match, strobe && !result.last,
                   result.status == irmt_pkg::ST_MATCH)
  // Insert outcomes are single results
  `IRMT_ASSERT_NOW(a_insert_single, strobe && (result.status == irmt_pkg::ST_INSERTED ||
                   result.status == irmt_pkg::ST_FULL), result.last && !busy)

endmodule

// ===== dv/ip_range_match_table_top_test.sv =====
// Self-checking testbench of the address range match table, with driver, monitor and shadow table.
module ip_range_match_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import irmt_pkg::*;

  localparam int TABLE_SIZE = MAX_ENTRIES_DEF;
  localparam int DIRECTED_GAP = 3;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   item = '0;
  logic       strobe;
  out_item_t  result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = '0;

  ip_range_match_table_top DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .strobe    (strobe),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6ns clk = ~clk;

  // Shadow copy of the range table and its depth setting
  logic [31:0] shadow_lo    [TABLE_SIZE];
  logic [31:0] shadow_hi    [TABLE_SIZE];
  logic [15:0] shadow_tag   [TABLE_SIZE];
  logic [1:0]  shadow_level [TABLE_SIZE];
  int          shadow_count = 0;
  logic [1:0]  shadow_depth = DEPTH_RESET;

  // Requests waiting for the driver, replies the table still owes
  in_item_t    queued_requests [$];
  out_item_t   table_replies [$];
  out_item_t   want;

  // Ranges handed to the table, kept for aiming lookups at them
  logic [31:0] made_lo [$];
  logic [31:0] made_hi [$];

  int unsigned hold_off = 0;
  int unsigned gap_max = 0;
  int          queued_total = 0;
  int          accepted = 0;
  int          errors = 0;
  int          cycles = 0;
  int          inserts_done = 0;
  int          inserts_refused = 0;
  int          lookups_done = 0;
  int          match_count = 0;
  int          miss_count = 0;
  int          depth_writes = 0;

  // Byte index of the first difference from the top, capped at the effective depth
  function automatic logic [1:0] split_level(logic [31:0] lo, logic [31:0] hi,
                                             logic [1:0] depth);
    int unsigned levels;
    levels = (depth == DEPTH_DEEP) ? 3 : 2;
    for (int unsigned b = 0; b < levels; b++) begin
      if (lo[31 - 8 * b -: 8] != hi[31 - 8 * b -: 8]) return b[1:0];
    end
    return levels[1:0];
  endfunction

  // Update the shadow table for one accepted request and queue the replies it owes
  task automatic predict_replies(in_item_t req);
    logic [15:0] hits [$];
    out_item_t   reply;
    if (req.mode == MODE_INSERT) begin
      reply.match_tag = '0;
      reply.last = 1'b1;
      if (shadow_count >= TABLE_SIZE) begin
        reply.status = ST_FULL;
        inserts_refused++;
      end else begin
        shadow_lo[shadow_count] = req.range_low;
        shadow_hi[shadow_count] = req.range_high;
        shadow_tag[shadow_count] = req.entry_tag;
        shadow_level[shadow_count] = split_level(req.range_low, req.range_high, shadow_depth);
        shadow_count++;
        reply.status = ST_INSERTED;
        inserts_done++;
      end
      table_replies.push_back(reply);
    end else begin
      lookups_done++;
      // walk level by level, entries in insertion order
      for (int lvl = 0; lvl < 4; lvl++) begin
        for (int e = 0; e < shadow_count; e++) begin
          if (shadow_level[e] == lvl && req.lookup_addr >= shadow_lo[e] &&
              req.lookup_addr <= shadow_hi[e]) begin
            hits.push_back(shadow_tag[e]);
          end
        end
      end
      if (hits.size() == 0) begin
        miss_count++;
        table_replies.push_back('{status: ST_NOMATCH, match_tag: 16'h0, last: 1'b1});
      end else begin
        match_count += hits.size();
        foreach (hits[i]) begin
          table_replies.push_back('{status: ST_MATCH, match_tag: hits[i],
                                    last: (i == hits.size() - 1)});
        end
      end
    end
  endtask

  // Address clustered around a few prefixes so that ranges nest and overlap
  function automatic logic [31:0] near_addr();
    logic [7:0]  top;
    logic [7:0]  second;
    logic [31:0] noise;
    noise = $urandom;
    case ($urandom_range(0, 4))
      0: top = 8'h00;
      1: top = 8'h0A;
      2: top = 8'hC0;
      3: top = 8'hFF;
      default: top = noise[31:24];
    endcase
    case ($urandom_range(0, 3))
      0: second = 8'h00;
      1: second = 8'h0B;
      2: second = 8'hFF;
      default: second = noise[23:16];
    endcase
    return {top, second, noise[15:0]};
  endfunction

  // Random request: mostly shaped ranges and lookups aimed at stored ranges
  function automatic in_item_t random_request();
    in_item_t    req;
    logic [31:0] base;
    logic [31:0] mask;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [32:0] span;
    int unsigned k;
    int unsigned free_bytes;
    req.mode = MODE_LOOKUP;
    req.range_low = $urandom;
    req.range_high = $urandom;
    req.entry_tag = $urandom;
    req.lookup_addr = $urandom;
    if ($urandom_range(0, 99) < 22) begin
      req.mode = MODE_INSERT;
      if ($urandom_range(0, 9) != 0) begin
        free_bytes = $urandom_range(0, 4);
        mask = (free_bytes == 4) ? 32'h0 : (32'hFFFF_FFFF >> (8 * free_bytes));
        base = near_addr();
        lo = base & ~(mask & $urandom);
        hi = base | (mask & $urandom);
        // now and then a reversed range
        if ($urandom_range(0, 9) == 0) {lo, hi} = {hi, lo};
        req.range_low = lo;
        req.range_high = hi;
      end
    end else if (made_lo.size() != 0 && $urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, made_lo.size() - 1);
      lo = made_lo[k];
      hi = made_hi[k];
      span = {1'b0, hi} - {1'b0, lo} + 33'd1;
      case ($urandom_range(0, 4))
        0: req.lookup_addr = lo;
        1: req.lookup_addr = hi;
        2: req.lookup_addr = lo - 32'd1;
        3: req.lookup_addr = hi + 32'd1;
        default: if (hi >= lo) req.lookup_addr = lo + 32'($urandom % span);
      endcase
    end else if ($urandom_range(0, 1) == 0) begin
      req.lookup_addr = near_addr();
    end
    return req;
  endfunction

  task automatic queue_request(in_item_t req);
    if (req.mode == MODE_INSERT && made_lo.size() < TABLE_SIZE) begin
      made_lo.push_back(req.range_low);
      made_hi.push_back(req.range_high);
    end
    queued_requests.push_back(req);
    queued_total++;
  endtask

  task automatic insert_range(logic [31:0] lo, logic [31:0] hi, logic [15:0] tag);
    in_item_t req;
    req.mode = MODE_INSERT;
    req.range_low = lo;
    req.range_high = hi;
    req.entry_tag = tag;
    req.lookup_addr = $urandom;
    queue_request(req);
  endtask

  task automatic lookup(logic [31:0] addr);
    in_item_t req;
    req.mode = MODE_LOOKUP;
    req.range_low = $urandom;
    req.range_high = $urandom;
    req.entry_tag = $urandom;
    req.lookup_addr = addr;
    queue_request(req);
  endtask

  // Idle: every queued request transferred, every reply seen, block not busy
  task automatic wait_table_idle();
    while (accepted != queued_total || table_replies.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_depth(logic [1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_depth = value;
    depth_writes++;
  endtask

  // Driver: presents queued requests with random hold-offs between transfers
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_replies(item);
        accepted++;
        hold_off = $urandom_range(0, gap_max);
      end
      if (!start || !busy) begin
        if (hold_off != 0) begin
          hold_off--;
          start <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          item <= queued_requests.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed result against the oldest owed reply
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (table_replies.size() == 0) begin
        $display("%0t: result with nothing owed: status %0d tag %h last %b",
                 $time, result.status, result.match_tag, result.last);
        errors++;
      end else begin
        want = table_replies.pop_front();
        if (result.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d got %0d",
                   $time, want.status, result.status);
          errors++;
        end
        if (result.match_tag !== want.match_tag) begin
          $display("%0t: match_tag mismatch: expected %h got %h",
                   $time, want.match_tag, result.match_tag);
          errors++;
        end
        if (result.last !== want.last) begin
          $display("%0t: last mismatch: expected %b got %b", $time, want.last, result.last);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d replies still owed",
               $time, cycles, table_replies.size());
      $display("ip_range_match_table_top_test: errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    gap_max = DIRECTED_GAP;

    // Reset depth: empty table, reversed extreme range, nested ranges
    lookup(32'h0000_0000);
    insert_range(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF);
    insert_range(32'h0A00_0000, 32'h0AFF_FFFF, 16'h0000);
    insert_range(32'h0A0B_0C00, 32'h0A0B_0CFF, 16'h1111);
    insert_range(32'h0A0B_0C0D, 32'h0A0B_0C0D, 16'h2222);
    insert_range(32'h0000_0000, 32'h0000_00FF, 16'h3333);
    lookup(32'h0A0B_0C0D);
    lookup(32'h0000_0000);
    lookup(32'hFFFF_FFFF);
    wait_table_idle();

    // Deep setting: last-byte level, later inserts sorted under earlier levels
    set_depth(DEPTH_DEEP);
    insert_range(32'h0A0B_0C20, 32'h0A0B_0C2F, 16'h4444);
    insert_range(32'h0A0B_0000, 32'h0A0B_FFFF, 16'h5555);
    insert_range(32'h0900_0000, 32'h0BFF_FFFF, 16'h8888);
    insert_range(32'hFFFF_FF00, 32'hFFFF_FFFF, 16'h9999);
    lookup(32'h0A0B_0C25);
    lookup(32'hFFFF_FFFF);
    wait_table_idle();

    // Out-of-range depth codes behave as the shallow setting
    set_depth(2'd0);
    insert_range(32'h0A0B_0C30, 32'h0A0B_0C30, 16'h6666);
    lookup(32'h0A0B_0C30);
    wait_table_idle();
    set_depth(2'd1);
    insert_range(32'h0102_0304, 32'h0102_0305, 16'h7777);
    lookup(32'h0102_0304);
    lookup(32'h0A0B_0C10);

    // Random phases, each under its own depth and pacing
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_table_idle();
      set_depth((p == 0) ? DEPTH_RESET : 2'($urandom_range(0, 3)));
      gap_max = (p % 3 == 2) ? 0 : 3;
      repeat (ITEMS_PER_PHASE) queue_request(random_request());
    end

    wait_table_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d stored inserts, %0d refused on a full table, %0d lookups",
             inserts_done, inserts_refused, lookups_done);
    $display("lookups gave %0d matches and %0d misses; %0d depth writes in %0d cycles",
             match_count, miss_count, depth_writes, cycles);
    if (errors == 0 && table_replies.size() == 0) begin
      $display("ip_range_match_table_top_test: clean");
    end else begin
      $display("ip_range_match_table_top_test: errors");
    end
    $finish;
  end

endmodule
